### rtl/fitness_overselect_interval_table_assert.svh
// assertion macros for the interval table block
`ifndef FITNESS_OVERSELECT_INTERVAL_TABLE_ASSERT_SVH
`define FITNESS_OVERSELECT_INTERVAL_TABLE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FOIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FOIT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/foit_pkg.sv
// ----------------------------------------------------------------------------
// foit_pkg
// shared types and constants of the fitness overselection interval table
// ----------------------------------------------------------------------------
package foit_pkg;
  localparam int unsigned MaxPopDefault = 64;
  localparam int unsigned FitW   = 32;
  localparam int unsigned CumW   = 38;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned FracW  = 17;
  localparam logic [FracW-1:0] OneQ16 = 17'd65536;
  localparam logic [FracW-1:0] CutoffReset = 17'd20972;
  localparam logic [FracW-1:0] PropReset   = 17'd52429;
  localparam logic [0:0] RegCutoff = 1'b0;
  localparam logic [0:0] RegProp   = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,   // read element i
    ST_SORT_CMP,  // read element j-1
    ST_SORT_CHK,  // compare and shift
    ST_SORT_PUT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_CUT,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_OUT
  } state_t;

  function automatic logic [FracW-1:0] sat_one(input logic [FracW-1:0] v);
    return (v > OneQ16) ? OneQ16 : v;
  endfunction
endpackage

### rtl/fitness_overselect_interval_table.sv
// ----------------------------------------------------------------------------
// fitness_overselect_interval_table
// builds the cumulative roulette interval table with fitness overselection
// ----------------------------------------------------------------------------
// Items load one per cycle (busy low) into a table memory with one read and one
// write port. On the item marked last the block goes busy: a stable insertion
// sort of the n members, then a summing pass, then the cutoff product, then the
// output pass, which emits the results in sorted order. The receiver cannot
// stall: out_valid is high exactly one cycle per result. busy drops in the cycle
// that carries the result with table_end, and register writes are held off
// (cfg_ready low) while busy.
module fitness_overselect_interval_table
  import foit_pkg::*;
#(
  parameter int unsigned MAX_POP = MaxPopDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [FitW-1:0]  in_fitness_value,
  input  logic             in_last_member,
  output logic             out_valid,
  output logic [CumW-1:0]  out_cumulative_weight,
  output logic [IdxW-1:0]  out_member_index,
  output logic             out_table_end,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [FracW-1:0] cfg_data
);
`include "fitness_overselect_interval_table_assert.svh"

  localparam int unsigned AW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_POP);

  // table memory: fitness and arrival index side by side
  logic [FitW+IdxW-1:0] mem [MAX_POP];
  logic [FitW+IdxW-1:0] rd_q;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [FitW+IdxW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [FitW+IdxW-1:0] key_r, key_nxt;
  logic [CumW-1:0] total_r, total_nxt, prev_r, prev_nxt, cum_r, cum_nxt;
  logic [CumW+FracW-1:0] cut_r, cut_nxt;
  logic [FracW-1:0] cutoff_r, prop_r;
  logic [FitW+FracW-1:0] prod_r, prod_nxt;
  logic [FitW-1:0] f_r, f_nxt;

  assign busy = (state_r != ST_LOAD);
  assign cfg_ready = !busy;
  wire accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CutoffReset;
      prop_r   <= PropReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegCutoff) cutoff_r <= cfg_data;
      else prop_r <= cfg_data;
    end
  end

  logic [FracW-1:0] wtop, wrest, wsel;
  assign wtop  = sat_one(prop_r);
  assign wrest = OneQ16 - wtop;
  assign wsel  = ({1'b0, prev_r, 16'd0} >= cut_r) ? wtop : wrest;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; key_nxt = key_r;
    total_nxt = total_r; prev_nxt = prev_r; cum_nxt = cum_r; cut_nxt = cut_r;
    prod_nxt = prod_r; f_nxt = f_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_r < MaxCnt) cnt_nxt = cnt_r + 1'b1;
          if (in_last_member) begin
            i_nxt = CW'(1);
            state_nxt = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        if (i_r >= cnt_nxt) begin
          i_nxt = '0; total_nxt = '0;
          state_nxt = ST_SUM_RD;
        end else begin
          j_nxt = i_r;
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (j_r == i_r) key_nxt = rd_q; // element i arrives on the first pass only
        state_nxt = ST_SORT_CHK;
      end
      ST_SORT_CHK: begin
        // rd_q holds element j-1 (read last cycle)
        if (rd_q[FitW+IdxW-1:IdxW] > key_r[FitW+IdxW-1:IdxW]) begin
          j_nxt = j_r - 1'b1;
          if (j_r == CW'(1)) state_nxt = ST_SORT_PUT;
          else state_nxt = ST_SORT_CMP;
        end else begin
          state_nxt = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: begin
        i_nxt = i_r + 1'b1;
        state_nxt = ST_SORT_RD;
      end
      ST_SUM_RD: begin
        state_nxt = (i_r >= cnt_r) ? ST_CUT : ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        total_nxt = total_r + CumW'(rd_q[FitW+IdxW-1:IdxW]);
        i_nxt = i_r + 1'b1;
        state_nxt = ST_SUM_RD;
      end
      ST_CUT: begin
        cut_nxt = (CumW+FracW)'(total_r * (OneQ16 - sat_one(cutoff_r)));
        i_nxt = '0; prev_nxt = '0; cum_nxt = '0;
        state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_MUL;
      ST_EMIT_MUL: begin
        f_nxt = rd_q[FitW+IdxW-1:IdxW];
        prod_nxt = rd_q[FitW+IdxW-1:IdxW] * wsel;
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        cum_nxt = cum_r + CumW'(prod_r[FitW+FracW-1:16]);
        prev_nxt = prev_r + CumW'(f_r);
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = '0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // memory access per state
  always_comb begin
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = {in_fitness_value, IdxW'(cnt_r)};
    raddr = i_r[AW-1:0];
    unique case (state_r)
      ST_LOAD: we = accept && (cnt_r < MaxCnt);
      ST_SORT_RD: raddr = i_r[AW-1:0];
      ST_SORT_CMP: raddr = AW'(j_r - 1'b1);
      ST_SORT_CHK: begin
        // shift j-1 up, then fetch next predecessor
        we = rd_q[FitW+IdxW-1:IdxW] > key_r[FitW+IdxW-1:IdxW];
        waddr = j_r[AW-1:0];
        wdata = rd_q;
        raddr = AW'(j_r - CW'(2));
      end
      ST_SORT_PUT: begin
        we = 1'b1;
        waddr = j_r[AW-1:0];
        wdata = key_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
      i_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      i_r <= i_nxt;
      out_valid <= (state_r == ST_EMIT_OUT);
    end
  end

  logic [IdxW-1:0] idx_r;
  always_ff @(posedge clk) begin
    j_r <= j_nxt; key_r <= key_nxt; total_r <= total_nxt;
    prev_r <= prev_nxt; cum_r <= cum_nxt; cut_r <= cut_nxt;
    prod_r <= prod_nxt; f_r <= f_nxt;
    if (state_r == ST_EMIT_MUL) idx_r <= rd_q[IdxW-1:0];
    if (state_r == ST_EMIT_OUT) begin
      out_cumulative_weight <= cum_nxt;
      out_member_index <= idx_r;
      out_table_end <= (i_r + 1'b1 >= cnt_r);
    end
  end

  `FOIT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= MaxCnt, "load count above limit")
  `FOIT_ASSERT_NXT(a_out_gap, out_valid, !out_valid, "results on adjacent cycles")
  `FOIT_ASSERT_IMP(a_end_idle, out_valid && out_table_end, !busy, "busy at table end")
  `FOIT_ASSERT_IMP(a_out_busy, out_valid && !out_table_end, busy, "result while idle")
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the overselection interval table builder
// ----------------------------------------------------------------------------
// Populations are loaded with random burst gaps, the table is predicted with a
// stable sort, the cutoff split and the weighted running sum, and every strobe
// is compared against the oldest predicted entry. The registers are swept
// between populations, including the saturated values above one.
module tb;
  import foit_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    logic [CumW-1:0] cum;
    logic [IdxW-1:0] idx;
    logic            tend;
  } entry_t;

  typedef struct {
    logic [FitW-1:0] fit;
    logic            last;
    bit              chk;
    logic [CumW-1:0] cum;
    logic [IdxW-1:0] idx;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [FitW-1:0]  in_fitness_value = '0;
  logic             in_last_member = 1'b0;
  logic             out_valid;
  logic [CumW-1:0]  out_cumulative_weight;
  logic [IdxW-1:0]  out_member_index;
  logic             out_table_end;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [0:0]       cfg_index = RegCutoff;
  logic [FracW-1:0] cfg_data = '0;

  fitness_overselect_interval_table DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [FitW-1:0]  pop_fit[$];
  logic [FracW-1:0] cut_reg = CutoffReset;
  logic [FracW-1:0] prop_reg = PropReset;
  entry_t           table_q[$];
  entry_t           pinned_q[$];
  bit               pinned_on[$];
  int errors = 0, mism = 0, cycles = 0, items = 0, tables = 0, entries = 0;

  task automatic build_table();
    logic [FitW-1:0] f[$];
    int              ix[$];
    logic [FitW-1:0] tf;
    int              ti, j;
    logic [63:0]     total, cutsc, prev, cum, wt, wr, w;
    entry_t          e;
    f = pop_fit;
    for (int i = 0; i < f.size(); i++) ix.push_back(i);
    for (int i = 1; i < f.size(); i++) begin
      tf = f[i]; ti = ix[i]; j = i;
      while (j > 0 && f[j-1] > tf) begin
        f[j] = f[j-1]; ix[j] = ix[j-1]; j--;
      end
      f[j] = tf; ix[j] = ti;
    end
    total = 0;
    foreach (f[i]) total += f[i];
    cutsc = total * (64'(OneQ16) - 64'(cut_reg > OneQ16 ? OneQ16 : cut_reg));
    wt = (prop_reg > OneQ16) ? 64'(OneQ16) : 64'(prop_reg);
    wr = 64'(OneQ16) - wt;
    prev = 0; cum = 0;
    foreach (f[i]) begin
      w = (prev * 65536 >= cutsc) ? wt : wr;
      cum += (64'(f[i]) * w) >> 16;
      prev += f[i];
      e.cum = cum[CumW-1:0]; e.idx = ix[i][IdxW-1:0]; e.tend = (i == f.size() - 1);
      table_q.push_back(e);
    end
    pop_fit.delete();
  endtask

  task automatic accept_item(input logic [FitW-1:0] fit, input logic last);
    if (pop_fit.size() < 64) pop_fit.push_back(fit);
    if (last) begin
      build_table();
      tables++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      entries <= entries + 1;
      if (table_q.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected entry cum=%0d idx=%0d",
                                  out_cumulative_weight, out_member_index);
      end else begin
        entry_t e;
        e = table_q.pop_front();
        if (pinned_q.size() > 0 && pinned_on[0]) begin
          if (pinned_q[0].cum !== e.cum || pinned_q[0].idx !== e.idx) begin
            errors++;
            if (mism++ < 10) $display("directed row disagrees with predictor");
          end
        end
        if (pinned_q.size() > 0) begin
          void'(pinned_q.pop_front());
          void'(pinned_on.pop_front());
        end
        if (out_cumulative_weight !== e.cum || out_member_index !== e.idx ||
            out_table_end !== e.tend) begin
          errors++;
          if (mism++ < 10)
            $display("mismatch exp cum=%0d idx=%0d end=%0b got cum=%0d idx=%0d end=%0b",
                     e.cum, e.idx, e.tend, out_cumulative_weight,
                     out_member_index, out_table_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [FitW-1:0] fit, input logic last);
    @(negedge clk);
    start <= 1'b1;
    in_fitness_value <= fit;
    in_last_member <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    accept_item(fit, last);
    items++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic burst_gap();
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  task automatic drain();
    while (table_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [FracW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == RegCutoff) cut_reg = val; else prop_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  row_t rows[$];

  task automatic add_row(input logic [FitW-1:0] fit, input logic last, input bit chk,
                         input logic [CumW-1:0] cum, input logic [IdxW-1:0] idx);
    row_t r;
    r.fit = fit; r.last = last; r.chk = chk; r.cum = cum; r.idx = idx;
    rows.push_back(r);
  endtask

  task automatic random_pop(input int n, input bit wide);
    logic [FitW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom_range(0, 3) << 16;
        1: v = '1;
        default: v = wide ? $urandom : $urandom_range(0, 32'h000f_ffff);
      endcase
      send_item(v, i == n - 1);
      burst_gap();
    end
  endtask

  initial begin
    entry_t dummy;
    int     n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single member sits below the cutoff, weighted by one minus proportion
    add_row(32'h0001_0000, 1'b1, 1'b1, 38'd13107, 6'd0);
    // zero and max fitness, ties, last of a lone zero
    add_row('0, 1'b1, 1'b1, 38'd0, 6'd0);
    add_row(32'hffff_ffff, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_0000, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_0005, 1'b0, 1'b0, '0, '0);
    add_row(32'h0000_0005, 1'b1, 1'b0, '0, '0);
    foreach (rows[k]) begin
      if (rows[k].chk) begin
        dummy.cum = rows[k].cum; dummy.idx = rows[k].idx; dummy.tend = 1'b1;
        pinned_q.push_back(dummy); pinned_on.push_back(1'b1);
      end else if (rows[k].last) begin
        for (int m = 0; m < 4; m++) begin
          pinned_q.push_back(dummy); pinned_on.push_back(1'b0);
        end
      end
      send_item(rows[k].fit, rows[k].last);
      if (rows[k].last) drain();
    end

    // register extremes, including values above one
    write_reg(RegCutoff, 17'd0);     write_reg(RegProp, 17'd65536);
    random_pop(4, 1'b1);  drain();
    write_reg(RegCutoff, 17'd65536); write_reg(RegProp, 17'd0);
    random_pop(5, 1'b1);  drain();
    write_reg(RegCutoff, 17'h1ffff); write_reg(RegProp, 17'h1ffff);
    random_pop(3, 1'b1);  drain();

    // overflow: 66 items, the last two dropped
    for (int i = 0; i < 66; i++) send_item($urandom, i == 65);
    drain();

    // random populations with random settings, small sizes mostly
    while (items < 100) begin
      write_reg(RegCutoff, FracW'($urandom_range(0, 17'h1ffff)));
      if ($urandom_range(0, 1)) write_reg(RegProp, FracW'($urandom_range(0, 17'h1ffff)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      if (n > 104 - items) n = 104 - items;
      random_pop(n, 1'($urandom_range(0, 1)));
      drain();
    end

    repeat (20) @(posedge clk);
    $display("sent %0d items, %0d tables, %0d entries checked, %0d errors",
             items, tables, entries, errors);
    $display("register extremes, overflow and tie ordering were exercised");
    if (errors == 0 && table_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
